[rtl/crcpo_pkg.sv]
// shared types and constants for the circle versus rectangle push-out block
package crcpo_pkg;

  // the near threshold is 0.0001 = 1 / NEAR_DEN in squared coordinate units
  localparam longint unsigned NEAR_DEN = 64'd10000;

  // depth of the queues between the front, the back and the result port
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/crcpo_fifo.sv]
// small register queue used between the front, the back and the result port
module crcpo_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 pop,
  input  logic [WIDTH-1:0]     din,
  output logic [WIDTH-1:0]     dout,
  output crcpo_pkg::fifo_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] ent_r [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/crcpo_front.sv]
// front stage: rectangle edges, closest point and the coarse range check
module crcpo_front #(
  parameter int C = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                adv,
  input  logic [C-1:0]        center_x,
  input  logic [C-1:0]        center_y,
  input  logic [C-2:0]        radius,
  input  logic [C-1:0]        rect_left,
  input  logic [C-1:0]        rect_top,
  input  logic [C-2:0]        rect_width,
  input  logic [C-2:0]        rect_height,
  output logic                valid,
  output logic signed [C-1:0] cx,
  output logic signed [C-1:0] cy,
  output logic [C-2:0]        r,
  output logic signed [C-1:0] left,
  output logic signed [C-1:0] top,
  output logic signed [C:0]   right,
  output logic signed [C:0]   bottom,
  output logic signed [C:0]   px,
  output logic signed [C:0]   py,
  output logic [C-2:0]        adx,
  output logic [C-2:0]        ady,
  output logic                sdx,
  output logic                sdy,
  output logic                inr
);

  logic               v_r, v_nxt;
  logic signed [C:0]  lefte, tope, righte, bottome, cxe, cye, pxc, pyc;
  logic signed [C+1:0] dx, dy;
  logic [C+1:0]       adxw, adyw;
  logic               inr_c;

  assign valid = v_r;

  always_comb begin
    lefte   = {rect_left[C-1], rect_left};
    tope    = {rect_top[C-1], rect_top};
    cxe     = {center_x[C-1], center_x};
    cye     = {center_y[C-1], center_y};
    righte  = lefte + $signed({2'b00, rect_width});
    bottome = tope + $signed({2'b00, rect_height});
    if (cxe < lefte) begin
      pxc = lefte;
    end else if (cxe > righte) begin
      pxc = righte;
    end else begin
      pxc = cxe;
    end
    if (cye < tope) begin
      pyc = tope;
    end else if (cye > bottome) begin
      pyc = bottome;
    end else begin
      pyc = cye;
    end
    dx    = {cxe[C], cxe} - {pxc[C], pxc};
    dy    = {cye[C], cye} - {pyc[C], pyc};
    adxw  = dx[C+1] ? $unsigned(-dx) : $unsigned(dx);
    adyw  = dy[C+1] ? $unsigned(-dy) : $unsigned(dy);
    inr_c = (adxw < {3'b000, radius}) && (adyw < {3'b000, radius});
    v_nxt = load || (v_r && !adv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cx     <= $signed(center_x);
      cy     <= $signed(center_y);
      r      <= radius;
      left   <= $signed(rect_left);
      top    <= $signed(rect_top);
      right  <= righte;
      bottom <= bottome;
      px     <= pxc;
      py     <= pyc;
      // only meaningful when in range, where it is below the radius
      adx    <= adxw[C-2:0];
      ady    <= adyw[C-2:0];
      sdx    <= dx[C+1];
      sdy    <= dy[C+1];
      inr    <= inr_c;
    end
  end

endmodule

[rtl/crcpo_back.sv]
// back pipeline: squares, inside push-out, hit test, square root, normal divide and saturation
module crcpo_back #(
  parameter int C = 24,
  parameter int F = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  logic signed [C-1:0] cx,
  input  logic signed [C-1:0] cy,
  input  logic [C-2:0]        r,
  input  logic signed [C-1:0] left,
  input  logic signed [C-1:0] top,
  input  logic signed [C:0]   right,
  input  logic signed [C:0]   bottom,
  input  logic signed [C:0]   px,
  input  logic signed [C:0]   py,
  input  logic [C-2:0]        adx,
  input  logic [C-2:0]        ady,
  input  logic                sdx,
  input  logic                sdy,
  input  logic                inr,
  output logic                last_v,
  output logic                collided,
  output logic [C-1:0]        ox,
  output logic [C-1:0]        oy
);

  localparam int G   = (65 - 2 * C) / 2;
  localparam int SQ  = C - 1 + G;
  localparam int NXW = 2 * C - 2 + G;
  localparam int NW  = NXW + 1;
  localparam int LW  = 2 * C - 1;
  localparam longint unsigned NEAR_FULL =
    ((64'd1 << (2 * F)) + crcpo_pkg::NEAR_DEN - 64'd1) / crcpo_pkg::NEAR_DEN;
  localparam logic [LW-1:0] NEAR_T = LW'(NEAR_FULL);
  localparam logic signed [C+1:0] CMAX = {3'b000, {(C-1){1'b1}}};
  localparam logic signed [C+1:0] CMIN = {3'b111, {(C-1){1'b0}}};

  typedef struct packed {
    logic [2*C-3:0]      sqx;
    logic [2*C-3:0]      sqy;
    logic [2*C-3:0]      r2;
    logic [2*C-3:0]      mx;
    logic [2*C-3:0]      my;
    logic signed [C+1:0] oxn;
    logic signed [C+1:0] oyn;
    logic signed [C:0]   px;
    logic signed [C:0]   py;
    logic signed [C-1:0] cx;
    logic signed [C-1:0] cy;
    logic                sdx;
    logic                sdy;
    logic                inr;
  } s1_t;

  typedef struct packed {
    logic                hit;
    logic                near;
    logic signed [C+1:0] oxn;
    logic signed [C+1:0] oyn;
    logic signed [C:0]   px;
    logic signed [C:0]   py;
    logic signed [C-1:0] cx;
    logic signed [C-1:0] cy;
    logic                sdx;
    logic                sdy;
  } res_t;

  // ---------------- stage 1: products and the inside push-out
  s1_t                 s1_r;
  logic                s1_v_r;
  s1_t                 s1_c;
  logic signed [C+1:0] cx2, cy2, l2, t2, rt2, b2, re;
  logic signed [C+1:0] dl, dr, dt, db;
  logic [C+1:0]        pl, pr, pt, pb, m;

  always_comb begin
    cx2 = {{2{cx[C-1]}}, cx};
    cy2 = {{2{cy[C-1]}}, cy};
    l2  = {{2{left[C-1]}}, left};
    t2  = {{2{top[C-1]}}, top};
    rt2 = {right[C], right};
    b2  = {bottom[C], bottom};
    re  = $signed({3'b000, r});
    dl  = cx2 - l2;
    dr  = rt2 - cx2;
    dt  = cy2 - t2;
    db  = b2 - cy2;
    pl  = dl[C+1] ? $unsigned(-dl) : $unsigned(dl);
    pr  = dr[C+1] ? $unsigned(-dr) : $unsigned(dr);
    pt  = dt[C+1] ? $unsigned(-dt) : $unsigned(dt);
    pb  = db[C+1] ? $unsigned(-db) : $unsigned(db);
    m   = pl;
    if (pr < m) begin
      m = pr;
    end
    if (pt < m) begin
      m = pt;
    end
    if (pb < m) begin
      m = pb;
    end
    s1_c.oxn = cx2;
    s1_c.oyn = cy2;
    // least penetration wins, ties resolved left, right, top, bottom
    if (m == pl) begin
      s1_c.oxn = l2 - re;
    end else if (m == pr) begin
      s1_c.oxn = rt2 + re;
    end else if (m == pt) begin
      s1_c.oyn = t2 - re;
    end else begin
      s1_c.oyn = b2 + re;
    end
    s1_c.sqx = adx * adx;
    s1_c.sqy = ady * ady;
    s1_c.r2  = r * r;
    s1_c.mx  = adx * r;
    s1_c.my  = ady * r;
    s1_c.px  = px;
    s1_c.py  = py;
    s1_c.cx  = cx;
    s1_c.cy  = cy;
    s1_c.sdx = sdx;
    s1_c.sdy = sdy;
    s1_c.inr = inr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_c;
    end
  end

  // ---------------- stage 2: distance, hit test, root operand
  logic [LW-1:0]   len2;
  res_t            s2_res;
  logic [2*SQ-1:0] s2_n;
  logic [NXW-1:0]  s2_nx, s2_ny;

  always_comb begin
    len2          = LW'(s1_r.sqx) + LW'(s1_r.sqy);
    s2_res.hit    = s1_r.inr && (len2 < LW'(s1_r.r2));
    s2_res.near   = (len2 < NEAR_T);
    s2_res.oxn    = s1_r.oxn;
    s2_res.oyn    = s1_r.oyn;
    s2_res.px     = s1_r.px;
    s2_res.py     = s1_r.py;
    s2_res.cx     = s1_r.cx;
    s2_res.cy     = s1_r.cy;
    s2_res.sdx    = s1_r.sdx;
    s2_res.sdy    = s1_r.sdy;
    s2_n          = (2 * SQ)'(len2) << (2 * G);
    s2_nx         = NXW'(s1_r.mx) << G;
    s2_ny         = NXW'(s1_r.my) << G;
  end

  // ---------------- square root, one result bit per stage
  logic            sq_v_r    [0:SQ];
  res_t            sq_res_r  [0:SQ];
  logic [2*SQ-1:0] sq_n_r    [0:SQ];
  logic [SQ:0]     sq_rem_r  [0:SQ];
  logic [SQ-1:0]   sq_root_r [0:SQ];
  logic [NXW-1:0]  sq_nx_r   [0:SQ];
  logic [NXW-1:0]  sq_ny_r   [0:SQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_res_r[0]  <= s2_res;
      sq_n_r[0]    <= s2_n;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_nx_r[0]   <= s2_nx;
      sq_ny_r[0]   <= s2_ny;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [SQ+2:0] sh, trial, diff;
    logic          ge;

    always_comb begin
      sh    = {sq_rem_r[k], sq_n_r[k][2*SQ-1:2*SQ-2]};
      trial = {1'b0, sq_root_r[k], 2'b01};
      ge    = (sh >= trial);
      diff  = sh - trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_res_r[k+1]  <= sq_res_r[k];
        sq_n_r[k+1]    <= sq_n_r[k] << 2;
        sq_rem_r[k+1]  <= ge ? diff[SQ:0] : sh[SQ:0];
        sq_root_r[k+1] <= {sq_root_r[k][SQ-2:0], ge};
        sq_nx_r[k+1]   <= sq_nx_r[k];
        sq_ny_r[k+1]   <= sq_ny_r[k];
      end
    end
  end

  // ---------------- rounding term and divider setup
  logic [SQ-1:0] len_c;
  logic [NW-1:0] numx, numy;

  always_comb begin
    len_c = (sq_root_r[SQ] == '0) ? SQ'(1) : sq_root_r[SQ];
    numx  = NW'(sq_nx_r[SQ]) + NW'(len_c >> 1);
    numy  = NW'(sq_ny_r[SQ]) + NW'(len_c >> 1);
  end

  // ---------------- restoring divide, one quotient bit per stage
  logic          dv_v_r    [0:C];
  res_t          dv_res_r  [0:C];
  logic [SQ-1:0] dv_len_r  [0:C];
  logic [SQ-1:0] dv_remx_r [0:C];
  logic [SQ-1:0] dv_remy_r [0:C];
  logic [C-1:0]  dv_lowx_r [0:C];
  logic [C-1:0]  dv_lowy_r [0:C];
  logic [C-1:0]  dv_qx_r   [0:C];
  logic [C-1:0]  dv_qy_r   [0:C];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_res_r[0]  <= sq_res_r[SQ];
      dv_len_r[0]  <= len_c;
      // the quotient stays below 2^C, so the upper part is below the divisor
      dv_remx_r[0] <= numx[NW-1:C];
      dv_remy_r[0] <= numy[NW-1:C];
      dv_lowx_r[0] <= numx[C-1:0];
      dv_lowy_r[0] <= numy[C-1:0];
      dv_qx_r[0]   <= '0;
      dv_qy_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < C; k++) begin : g_div
    logic [SQ:0] tx, ty, lx, dxs, dys;
    logic        gx, gy;

    always_comb begin
      tx  = {dv_remx_r[k], dv_lowx_r[k][C-1]};
      ty  = {dv_remy_r[k], dv_lowy_r[k][C-1]};
      lx  = {1'b0, dv_len_r[k]};
      gx  = (tx >= lx);
      gy  = (ty >= lx);
      dxs = tx - lx;
      dys = ty - lx;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_res_r[k+1]  <= dv_res_r[k];
        dv_len_r[k+1]  <= dv_len_r[k];
        dv_remx_r[k+1] <= gx ? dxs[SQ-1:0] : tx[SQ-1:0];
        dv_remy_r[k+1] <= gy ? dys[SQ-1:0] : ty[SQ-1:0];
        dv_lowx_r[k+1] <= dv_lowx_r[k] << 1;
        dv_lowy_r[k+1] <= dv_lowy_r[k] << 1;
        dv_qx_r[k+1]   <= {dv_qx_r[k][C-2:0], gx};
        dv_qy_r[k+1]   <= {dv_qy_r[k][C-2:0], gy};
      end
    end
  end

  // ---------------- result select and saturation
  res_t                fin;
  logic signed [C+1:0] qx, qy, candx, candy, wx, wy;

  always_comb begin
    fin   = dv_res_r[C];
    qx    = $signed({2'b00, dv_qx_r[C]});
    qy    = $signed({2'b00, dv_qy_r[C]});
    candx = {fin.px[C], fin.px} + (fin.sdx ? -qx : qx);
    candy = {fin.py[C], fin.py} + (fin.sdy ? -qy : qy);
    if (!fin.hit) begin
      wx = {{2{fin.cx[C-1]}}, fin.cx};
      wy = {{2{fin.cy[C-1]}}, fin.cy};
    end else if (fin.near) begin
      wx = fin.oxn;
      wy = fin.oyn;
    end else begin
      wx = candx;
      wy = candy;
    end
    if (wx > CMAX) begin
      ox = CMAX[C-1:0];
    end else if (wx < CMIN) begin
      ox = CMIN[C-1:0];
    end else begin
      ox = wx[C-1:0];
    end
    if (wy > CMAX) begin
      oy = CMAX[C-1:0];
    end else if (wy < CMIN) begin
      oy = CMIN[C-1:0];
    end else begin
      oy = wy[C-1:0];
    end
    collided = fin.hit;
    last_v   = dv_v_r[C];
  end

endmodule

[rtl/circle_rect_collision_pushout.sv]
// circle versus axis-aligned rectangle collision test with push-out
//
// Input channel: an item (circle centre and radius, rectangle corner and
// size, Q16.8 by default) is taken on a clock edge with push high and full
// low. Result channel: while empty is low the oldest result (collided flag
// and the resolved centre) is on out_*, and pop takes it.
// One result per item, in order. A new beat can be taken every cycle while
// full is low. The pipeline depth comes from the square root, one root bit
// per stage (COORD_BITS-1+GUARD stages, GUARD = (65 - 2*COORD_BITS)/2),
// and the divider, one quotient bit per stage (COORD_BITS stages), both
// fully pipelined.
// A front stage feeds a two-entry queue; the back pipeline drains it and
// writes a two-entry result queue. When pop stays low the back pipeline
// freezes once its last stage holds a beat and the result queue is full,
// then the middle queue fills and full rises.
// Synchronous active-low reset empties all queues and stages; no clearing
// pass is needed.
module circle_rect_collision_pushout #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] in_center_x,
  input  logic [COORD_BITS-1:0] in_center_y,
  input  logic [COORD_BITS-2:0] in_radius,
  input  logic [COORD_BITS-1:0] in_rect_left,
  input  logic [COORD_BITS-1:0] in_rect_top,
  input  logic [COORD_BITS-2:0] in_rect_width,
  input  logic [COORD_BITS-2:0] in_rect_height,
  output logic                  empty,
  input  logic                  pop,
  output logic                  out_collided,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y
);

  localparam int C  = COORD_BITS;
  localparam int FW = 2 * C + (C - 1) + 2 * C + 4 * (C + 1) + 2 * (C - 1) + 3;
  localparam int OW = 1 + 2 * C;

  logic                f_v;
  logic signed [C-1:0] f_cx, f_cy, f_left, f_top;
  logic [C-2:0]        f_r, f_adx, f_ady;
  logic signed [C:0]   f_right, f_bottom, f_px, f_py;
  logic                f_sdx, f_sdy, f_inr;

  crcpo_pkg::fifo_stat_t mid_st, out_st;
  logic [FW-1:0]         mid_din, mid_dout;
  logic                  mid_push, mid_pop, accept, en;

  logic signed [C-1:0] b_cx, b_cy, b_left, b_top;
  logic [C-2:0]        b_r, b_adx, b_ady;
  logic signed [C:0]   b_right, b_bottom, b_px, b_py;
  logic                b_sdx, b_sdy, b_inr;

  logic                last_v, res_hit;
  logic [C-1:0]        res_x, res_y;
  logic [OW-1:0]       out_din, out_dout;
  logic                out_push;

  assign full     = f_v && mid_st.full;
  assign accept   = push && !full;
  assign mid_push = f_v && !mid_st.full;
  // the back pipeline only holds when its last beat has nowhere to go
  assign en       = !(last_v && out_st.full);
  assign mid_pop  = en && !mid_st.empty;
  assign out_push = last_v && en;

  crcpo_front #(.C(C)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (accept),
    .adv         (!mid_st.full),
    .center_x    (in_center_x),
    .center_y    (in_center_y),
    .radius      (in_radius),
    .rect_left   (in_rect_left),
    .rect_top    (in_rect_top),
    .rect_width  (in_rect_width),
    .rect_height (in_rect_height),
    .valid       (f_v),
    .cx          (f_cx),
    .cy          (f_cy),
    .r           (f_r),
    .left        (f_left),
    .top         (f_top),
    .right       (f_right),
    .bottom      (f_bottom),
    .px          (f_px),
    .py          (f_py),
    .adx         (f_adx),
    .ady         (f_ady),
    .sdx         (f_sdx),
    .sdy         (f_sdy),
    .inr         (f_inr)
  );

  assign mid_din = {f_cx, f_cy, f_r, f_left, f_top, f_right, f_bottom,
                    f_px, f_py, f_adx, f_ady, f_sdx, f_sdy, f_inr};

  crcpo_fifo #(.WIDTH(FW), .DEPTH(crcpo_pkg::QDEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .pop   (mid_pop),
    .din   (mid_din),
    .dout  (mid_dout),
    .stat  (mid_st)
  );

  assign {b_cx, b_cy, b_r, b_left, b_top, b_right, b_bottom,
          b_px, b_py, b_adx, b_ady, b_sdx, b_sdy, b_inr} = mid_dout;

  crcpo_back #(.C(C), .F(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (mid_pop),
    .cx       (b_cx),
    .cy       (b_cy),
    .r        (b_r),
    .left     (b_left),
    .top      (b_top),
    .right    (b_right),
    .bottom   (b_bottom),
    .px       (b_px),
    .py       (b_py),
    .adx      (b_adx),
    .ady      (b_ady),
    .sdx      (b_sdx),
    .sdy      (b_sdy),
    .inr      (b_inr),
    .last_v   (last_v),
    .collided (res_hit),
    .ox       (res_x),
    .oy       (res_y)
  );

  assign out_din = {res_hit, res_x, res_y};

  crcpo_fifo #(.WIDTH(OW), .DEPTH(crcpo_pkg::QDEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .pop   (pop),
    .din   (out_din),
    .dout  (out_dout),
    .stat  (out_st)
  );

  assign empty = out_st.empty;
  assign {out_collided, out_x, out_y} = out_dout;

`ifndef SYNTHESIS
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> f_v)
    else $error("accepted beat did not reach the front stage");

  a_tail_held: assert property (@(posedge clk) disable iff (!rst_n)
    (last_v && !en) |=> last_v)
    else $error("stalled back pipeline dropped its last beat");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop && !last_v) |=> !empty)
    else $error("waiting result vanished without a pop");
`endif

endmodule

[dv/tb_circle_rect_collision_pushout.sv]
// testbench for the circle versus rectangle collision and push-out block
`timescale 1ns / 100ps

module tb_circle_rect_collision_pushout;

  localparam int CB = 24;
  localparam int FB = 8;
  localparam int GUARD_BITS = (65 - 2 * CB) / 2;
  localparam longint CMAX = (longint'(1) <<< (CB - 1)) - 1;
  localparam longint CMIN = -(longint'(1) <<< (CB - 1));
  localparam longint unsigned NEAR_LIMIT =
    ((64'd1 << (2 * FB)) + crcpo_pkg::NEAR_DEN - 1) / crcpo_pkg::NEAR_DEN;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 600;

  typedef struct {
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic [CB-2:0]        r;
    logic signed [CB-1:0] left;
    logic signed [CB-1:0] top;
    logic [CB-2:0]        w;
    logic [CB-2:0]        h;
  } circle_rect_t;

  typedef struct {
    logic          hit;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } pushout_t;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  logic [CB-1:0] in_center_x, in_center_y, in_rect_left, in_rect_top;
  logic [CB-2:0] in_radius, in_rect_width, in_rect_height;
  logic empty;
  logic pop;
  logic out_collided;
  logic [CB-1:0] out_x, out_y;

  pushout_t expected_q[$];
  int err_count = 0;
  int idle_cycles = 0;
  int cycle_count = 0;
  int burst_left = 0;

  circle_rect_collision_pushout u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_center_x(in_center_x), .in_center_y(in_center_y), .in_radius(in_radius),
    .in_rect_left(in_rect_left), .in_rect_top(in_rect_top),
    .in_rect_width(in_rect_width), .in_rect_height(in_rect_height),
    .empty(empty), .pop(pop), .out_collided(out_collided), .out_x(out_x), .out_y(out_y)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CB-1:0] saturate(longint v);
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v[CB-1:0];
  endfunction

  function automatic longint normal_offset(longint d, longint r, longint unsigned len);
    longint unsigned m;
    m = (longint'(mag(d)) * r) << GUARD_BITS;
    m = (m + (len >> 1)) / len;
    return d < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic pushout_t compute_pushout(circle_rect_t it);
    longint cx, cy, r, left, top, right, bottom, px, py, dx, dy, ox, oy, m;
    longint pl, pr, pt, pb;
    longint unsigned dist2, len;
    pushout_t res;
    cx = longint'(it.cx);
    cy = longint'(it.cy);
    r = longint'({1'b0, it.r});
    left = longint'(it.left);
    top = longint'(it.top);
    right = left + longint'({1'b0, it.w});
    bottom = top + longint'({1'b0, it.h});
    px = clamp_range(cx, left, right);
    py = clamp_range(cy, top, bottom);
    dx = cx - px;
    dy = cy - py;
    ox = cx;
    oy = cy;
    res.hit = 1'b0;
    if (mag(dx) < r && mag(dy) < r) begin
      dist2 = dx * dx + dy * dy;
      if (dist2 < r * r) begin
        res.hit = 1'b1;
        if (dist2 < NEAR_LIMIT) begin
          // least penetration side, ties in order left, right, top, bottom
          pl = mag(cx - left);
          pr = mag(right - cx);
          pt = mag(cy - top);
          pb = mag(bottom - cy);
          m = pl;
          if (pr < m) m = pr;
          if (pt < m) m = pt;
          if (pb < m) m = pb;
          if (m == pl) ox = left - r;
          else if (m == pr) ox = right + r;
          else if (m == pt) oy = top - r;
          else oy = bottom + r;
        end else begin
          len = int_sqrt(dist2 << (2 * GUARD_BITS));
          if (len == 0) len = 1;
          ox = px + normal_offset(dx, r, len);
          oy = py + normal_offset(dy, r, len);
        end
      end
    end
    res.x = saturate(ox);
    res.y = saturate(oy);
    return res;
  endfunction

  task automatic report(string what, logic [CB-1:0] got, logic [CB-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // result side: receiver stall pattern, checking and watchdog
  always @(posedge clk) begin
    pushout_t want;
    int mode;
    logic accepted;
    accepted = 1'b0;
    if (rst_n) begin
      cycle_count++;
      if (push && !full) accepted = 1'b1;
      if (pop && !empty) begin
        accepted = 1'b1;
        if (expected_q.size() == 0) begin
          report("unexpected beat", out_x, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_collided !== want.hit) begin
            report("collided", CB'(out_collided), CB'(want.hit));
          end
          if (out_x !== want.x) report("out_x", out_x, want.x);
          if (out_y !== want.y) report("out_y", out_y, want.y);
        end
      end
      idle_cycles = accepted ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
    mode = (cycle_count / 97) % 4;
    case (mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(1, 0) == 1);
      2: pop <= ($urandom_range(9, 0) == 0);
      default: pop <= ((cycle_count % 24) < 4);
    endcase
  end

  task automatic send_item(circle_rect_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    in_center_x <= it.cx;
    in_center_y <= it.cy;
    in_radius <= it.r;
    in_rect_left <= it.left;
    in_rect_top <= it.top;
    in_rect_width <= it.w;
    in_rect_height <= it.h;
    push <= 1'b1;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    expected_q.insert(expected_q.size(), compute_pushout(it));
  endtask

  function automatic circle_rect_t make_item(longint cx, longint cy, longint r,
                                             longint left, longint top, longint w, longint h);
    circle_rect_t it;
    it.cx = cx[CB-1:0];
    it.cy = cy[CB-1:0];
    it.r = r[CB-2:0];
    it.left = left[CB-1:0];
    it.top = top[CB-1:0];
    it.w = w[CB-2:0];
    it.h = h[CB-2:0];
    return it;
  endfunction

  task automatic test_no_collision();
    send_item(make_item(0, 0, 0, -256, -256, 512, 512));        // zero radius
    send_item(make_item(5000, 0, 1000, 0, 0, 2000, 2000));      // far on x
    send_item(make_item(0, -3000, 1000, -100, 0, 200, 200));    // far on y
    send_item(make_item(3000, 3000, 1000, 0, 0, 2000, 2000));   // corner, just outside
  endtask

  task automatic test_normal_push();
    send_item(make_item(2500, 1000, 1000, 0, 0, 2000, 2000));
    send_item(make_item(-300, -400, 1000, 0, 0, 2000, 2000));
    send_item(make_item(2600, 2700, 1000, 0, 0, 2000, 2000));
    send_item(make_item(1000, -999, 1000, 0, 0, 2000, 2000));
    send_item(make_item(2001, 2001, 2, 0, 0, 2000, 2000));      // tiny offsets
  endtask

  task automatic test_inside();
    send_item(make_item(100, 1000, 500, 0, 0, 2000, 2000));     // left side
    send_item(make_item(1900, 1000, 500, 0, 0, 2000, 2000));    // right side
    send_item(make_item(1000, 50, 500, 0, 0, 2000, 2000));      // top side
    send_item(make_item(1000, 1950, 500, 0, 0, 2000, 2000));    // bottom side
    send_item(make_item(1000, 1000, 500, 0, 0, 2000, 2000));    // all tie
    send_item(make_item(1000, 500, 500, 0, 0, 2000, 1000));     // top and bottom tie
    send_item(make_item(2002, 1000, 500, 0, 0, 2000, 2000));    // just outside, near
    send_item(make_item(0, 0, 300, 0, 0, 0, 0));                // degenerate rect
  endtask

  task automatic test_extremes();
    send_item(make_item(CMAX, CMAX, CMAX, CMAX - 10, CMAX - 10, 100, 100));
    send_item(make_item(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX));
    send_item(make_item(CMIN + 5, 0, CMAX, CMIN, -100, CMAX, 200));
    send_item(make_item(CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX));
    send_item(make_item(CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX));
  endtask

  task automatic test_random();
    circle_rect_t it;
    longint left, top, w, h, r, span;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(9, 0) < 3) begin
        it.cx = CB'($urandom);
        it.cy = CB'($urandom);
        it.r = (CB-1)'($urandom);
        it.left = CB'($urandom);
        it.top = CB'($urandom);
        it.w = (CB-1)'($urandom);
        it.h = (CB-1)'($urandom);
      end else begin
        // circle placed around a rectangle so that many beats collide
        span = longint'(1) << $urandom_range(20, 2);
        left = $signed($urandom_range(2 * 1048576, 0)) - 1048576;
        top = $signed($urandom_range(2 * 1048576, 0)) - 1048576;
        w = $urandom_range(32'(span), 0);
        h = $urandom_range(32'(span), 0);
        r = $urandom_range(32'(span), 1);
        it = make_item(left + $signed($urandom_range(32'(w + 2 * r), 0)) - r,
                       top + $signed($urandom_range(32'(h + 2 * r), 0)) - r,
                       r, left, top, w, h);
      end
      send_item(it);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_center_x = '0;
    in_center_y = '0;
    in_radius = '0;
    in_rect_left = '0;
    in_rect_top = '0;
    in_rect_width = '0;
    in_rect_height = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_collision();
    test_normal_push();
    test_inside();
    test_extremes();
    test_random();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/crcpo_pkg.sv
rtl/crcpo_fifo.sv
rtl/crcpo_front.sv
rtl/crcpo_back.sv
rtl/circle_rect_collision_pushout.sv
dv/tb_circle_rect_collision_pushout.sv
